>>> design/b64d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the symbol lookup of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [15:0] CAP_RESET = 16'hFFFF;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_SYMBOL = 2'd1;
    localparam logic [1:0] STATUS_FULL       = 2'd2;

    // bit 6 is the valid flag, bits 5..0 the value
    localparam logic [6:0] SYM_VALID_ZERO = 7'h40;
    localparam logic [6:0] SYM_NONE       = 7'h00;

    localparam logic [5:0] SYM_LOWER_BASE = 6'd26;
    localparam logic [5:0] SYM_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SYM_PLUS       = 6'd62;
    localparam logic [5:0] SYM_SLASH      = 6'd63;

    typedef struct packed {
        logic [7:0] enc_char;
        logic       end_of_message;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_present;
        logic [1:0]  status;
        logic        last;
        logic        message_end;
        logic [15:0] written_count;
    } result_t;

    // one checked group: nbytes of zero means an error transaction
    typedef struct packed {
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [1:0]  nbytes;
        logic [1:0]  status;
        logic        eom;
        logic [15:0] base_count;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_head_t;

    function automatic logic [6:0] symbol_of(input logic [7:0] ch);
        logic [7:0] ofs;
        logic [6:0] sym;
        begin
            sym = SYM_NONE;
            ofs = 8'd0;
            if (ch >= "A" && ch <= "Z")
            begin
                ofs = ch - 8'(int'("A"));
                sym = {1'b1, ofs[5:0]};
            end
            else if (ch >= "a" && ch <= "z")
            begin
                ofs = ch - 8'(int'("a"));
                sym = {1'b1, ofs[5:0] + SYM_LOWER_BASE};
            end
            else if (ch >= "0" && ch <= "9")
            begin
                ofs = ch - 8'(int'("0"));
                sym = {1'b1, ofs[5:0] + SYM_DIGIT_BASE};
            end
            else if (ch == "+")
            begin
                sym = {1'b1, SYM_PLUS};
            end
            else if (ch == "/")
            begin
                sym = {1'b1, SYM_SLASH};
            end
            return sym;
        end
    endfunction

endpackage
`default_nettype wire

>>> design/b64d_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_queue
// Small job queue between the group checker and the result serializer.
// ----------------------------------------------------------------------------
module b64d_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    enq,
    input  wire  b64d_pkg::job_t   enq_job,
    output logic                   full,
    output b64d_pkg::job_head_t    head,
    input  wire                    deq
);
    import b64d_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          entries [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == FULL_CNT);
    assign head.valid = (cnt_reg != '0);
    assign head.job   = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!enq && deq)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entries[wr_ptr_reg] <= enq_job;
        end
    end

endmodule
`default_nettype wire

>>> design/b64d_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, gathers groups of up to four, checks their symbols and
// the capacity, and hands the decoded group to the job queue.
// ----------------------------------------------------------------------------
module b64d_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  wire  b64d_pkg::item_t item,
    input  wire                  q_full,
    output logic                 full,
    input  wire                  cfg_write_en,
    input  wire  [15:0]          cfg_write_data,
    output logic                 enq,
    output b64d_pkg::job_t       enq_job
);
    import b64d_pkg::*;

    logic [15:0] cap_reg, cap_next;
    logic [1:0]  phase_reg, phase_next;
    logic [6:0]  held_reg [3];
    logic [15:0] emitted_reg, emitted_next;
    logic        skip_reg, skip_next;

    logic        fire;
    logic        eom;
    logic        group_done;
    logic [6:0]  cur;
    logic [6:0]  s0, s1, s2, s3;
    logic        c_ok, d_ok;
    logic        bad_sym, no_room;
    logic        c_room, d_room;
    logic [16:0] used_after_c;
    logic [7:0]  b0, b1, b2;
    logic [1:0]  nbytes;

    assign full = q_full;
    assign fire = push && !q_full;
    assign eom  = item.end_of_message;
    assign cur  = symbol_of(item.enc_char);
    assign group_done = (phase_reg == 2'd3) || eom;

    always_comb
    begin
        s0 = (phase_reg == 2'd0) ? cur : held_reg[0];
        if (phase_reg == 2'd1)
        begin
            s1 = cur;
        end
        else if (phase_reg == 2'd0)
        begin
            s1 = SYM_VALID_ZERO;
        end
        else
        begin
            s1 = held_reg[1];
        end
        if (phase_reg == 2'd2)
        begin
            s2 = cur;
        end
        else if (phase_reg == 2'd3)
        begin
            s2 = held_reg[2];
        end
        else
        begin
            s2 = SYM_NONE;
        end
        s3 = (phase_reg == 2'd3) ? cur : SYM_NONE;
    end

    assign c_ok    = s2[6];
    assign d_ok    = s3[6];
    assign bad_sym = !s0[6] || !s1[6];
    assign no_room = (emitted_reg >= cap_reg);

    assign b0 = {s0[5:0], s1[5:4]};
    assign b1 = {s1[3:0], (c_ok ? s2[5:2] : 4'd0)};
    assign b2 = {(c_ok ? s2[1:0] : 2'd0), (d_ok ? s3[5:0] : 6'd0)};

    assign c_room       = c_ok && (({1'b0, emitted_reg} + 17'd1) < {1'b0, cap_reg});
    assign used_after_c = {1'b0, emitted_reg} + (c_room ? 17'd2 : 17'd1);
    assign d_room       = d_ok && (used_after_c < {1'b0, cap_reg});

    always_comb
    begin
        case ({c_room, d_room})
            2'b11:   nbytes = 2'd3;
            2'b10:   nbytes = 2'd2;
            2'b01:   nbytes = 2'd2;
            default: nbytes = 2'd1;
        endcase
    end

    assign enq = fire && !skip_reg && group_done;

    always_comb
    begin
        enq_job.byte0      = b0;
        enq_job.byte1      = c_room ? b1 : b2;
        enq_job.byte2      = b2;
        enq_job.eom        = eom;
        enq_job.base_count = emitted_reg;
        if (bad_sym)
        begin
            enq_job.nbytes = 2'd0;
            enq_job.status = STATUS_BAD_SYMBOL;
        end
        else if (no_room)
        begin
            enq_job.nbytes = 2'd0;
            enq_job.status = STATUS_FULL;
        end
        else
        begin
            enq_job.nbytes = nbytes;
            enq_job.status = STATUS_OK;
        end
    end

    always_comb
    begin
        cap_next     = cfg_write_en ? cfg_write_data : cap_reg;
        phase_next   = phase_reg;
        emitted_next = emitted_reg;
        skip_next    = skip_reg;
        if (fire)
        begin
            if (skip_reg)
            begin
                if (eom)
                begin
                    phase_next   = 2'd0;
                    emitted_next = '0;
                    skip_next    = 1'b0;
                end
            end
            else if (!group_done)
            begin
                phase_next = phase_reg + 2'd1;
            end
            else
            begin
                phase_next = 2'd0;
                if (eom)
                begin
                    emitted_next = '0;
                    skip_next    = 1'b0;
                end
                else if (bad_sym || no_room)
                begin
                    skip_next = 1'b1;
                end
                else
                begin
                    emitted_next = emitted_reg + {14'd0, nbytes};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= CAP_RESET;
            phase_reg   <= 2'd0;
            emitted_reg <= '0;
            skip_reg    <= 1'b0;
        end
        else
        begin
            cap_reg     <= cap_next;
            phase_reg   <= phase_next;
            emitted_reg <= emitted_next;
            skip_reg    <= skip_next;
        end
    end

    // held symbols are always rewritten before they are read
    always_ff @(posedge clk)
    begin
        if (fire && !skip_reg && !group_done)
        begin
            held_reg[phase_reg] <= cur;
        end
    end

endmodule
`default_nettype wire

>>> design/b64d_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_back
// Turns queued group jobs into result transactions through an output
// register, one per cycle while that register is empty or popped.
// ----------------------------------------------------------------------------
module b64d_back (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire  b64d_pkg::job_head_t head,
    output logic                     deq,
    output logic                     empty,
    input  wire                      pop,
    output b64d_pkg::result_t        result
);
    import b64d_pkg::*;

    logic     out_valid_reg, out_valid_next;
    result_t  out_data_reg;
    logic [1:0] idx_reg, idx_next;

    logic     can_load;
    logic     take;
    logic     is_err;
    logic     is_last;
    result_t  res;

    assign can_load = !out_valid_reg || pop;
    assign take     = head.valid && can_load;
    assign is_err   = (head.job.nbytes == 2'd0);
    assign is_last  = is_err || (idx_reg == (head.job.nbytes - 2'd1));
    assign deq      = take && is_last;

    always_comb
    begin
        res.last = 1'b1;
        if (is_err)
        begin
            res.out_byte      = 8'd0;
            res.byte_present  = 1'b0;
            res.status        = head.job.status;
            res.message_end   = 1'b1;
            res.written_count = head.job.base_count;
        end
        else
        begin
            case (idx_reg)
                2'd0:    res.out_byte = head.job.byte0;
                2'd1:    res.out_byte = head.job.byte1;
                default: res.out_byte = head.job.byte2;
            endcase
            res.byte_present  = 1'b1;
            res.status        = STATUS_OK;
            res.last          = is_last;
            res.message_end   = is_last && head.job.eom;
            res.written_count = head.job.base_count + {14'd0, idx_reg} + 16'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= res;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_data_reg;

endmodule
`default_nettype wire

>>> design/base64_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 decoder for a character stream, one character per transaction and
// up to three decoded bytes per completed group.
// ----------------------------------------------------------------------------
// path: a character that closes a group writes its job into the job queue,
//   and the first result is loaded into the output register once that is free
// throughput: one character per cycle unless full; results leave the serializer at
//   one per cycle, so a stalled result side fills the job queue and raises full
// reset: message state and job queue cleared, out_capacity back to 65535
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    output logic                  full,
    input  wire  b64d_pkg::item_t item,
    output logic                  empty,
    input  wire                   pop,
    output b64d_pkg::result_t     result,
    input  wire                   cfg_write_en,
    input  wire  [15:0]           cfg_write_data
);
    import b64d_pkg::*;

    logic      q_full;
    logic      enq;
    job_t      enq_job;
    job_head_t head;
    logic      deq;

    b64d_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .item           (item),
        .q_full         (q_full),
        .full           (full),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .enq            (enq),
        .enq_job        (enq_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .enq     (enq),
        .enq_job (enq_job),
        .full    (q_full),
        .head    (head),
        .deq     (deq)
    );

    b64d_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .deq    (deq),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule
`default_nettype wire

>>> tb/base64_decode_checker.sv
// ----------------------------------------------------------------------------
// base64_decode_checker
// Follows the character and result channels of the base64 stream decoder,
// decodes every accepted character with its own copy of the message state and
// compares each popped result field by field with the oldest decoded result.
// ----------------------------------------------------------------------------
module base64_decode_checker (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  wire                full,
    input  b64d_pkg::item_t    item,
    input  wire                empty,
    input  wire                pop,
    input  b64d_pkg::result_t  result,
    input  wire                cfg_write_en,
    input  wire  [15:0]        cfg_write_data,
    output int                 mismatches,
    output int                 outstanding
);

    b64d_pkg::result_t decoded_queue[$];

    logic [15:0] capacity;
    logic [1:0]  group_len;
    logic [6:0]  held_sym [3];
    logic [15:0] emitted;
    logic        skipping;
    int          fail_count;

    function automatic logic [6:0] symbol_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return {1'b1, 6'(c - "A")};
        end
        if (c >= "a" && c <= "z")
        begin
            return {1'b1, 6'(c - "a" + 8'd26)};
        end
        if (c >= "0" && c <= "9")
        begin
            return {1'b1, 6'(c - "0" + 8'd52)};
        end
        if (c == "+")
        begin
            return {1'b1, 6'd62};
        end
        if (c == "/")
        begin
            return {1'b1, 6'd63};
        end
        return b64d_pkg::SYM_NONE;
    endfunction

    task automatic clear_message();
        group_len = 2'd0;
        held_sym[0] = b64d_pkg::SYM_NONE;
        held_sym[1] = b64d_pkg::SYM_NONE;
        held_sym[2] = b64d_pkg::SYM_NONE;
        emitted = 16'd0;
        skipping = 1'b0;
    endtask

    task automatic abort_message(input logic [1:0] code, input logic eom);
        b64d_pkg::result_t r;
        r = '0;
        r.status = code;
        r.last = 1'b1;
        r.message_end = 1'b1;
        r.written_count = emitted;
        decoded_queue.push_back(r);
        if (eom)
        begin
            clear_message();
        end
        else
        begin
            skipping = 1'b1;
        end
    endtask

    task automatic decode_char(input b64d_pkg::item_t it);
        logic [6:0]        sym [4];
        logic [23:0]       triple;
        logic [7:0]        out_bytes [3];
        logic              c_ok;
        logic              d_ok;
        int                n;
        int                cnt;
        b64d_pkg::result_t r;
        if (skipping)
        begin
            if (it.end_of_message)
            begin
                clear_message();
            end
            return;
        end
        n = group_len;
        sym[0] = held_sym[0];
        sym[1] = held_sym[1];
        sym[2] = held_sym[2];
        sym[3] = b64d_pkg::SYM_NONE;
        sym[n] = symbol_value(it.enc_char);
        n++;
        if (n < 4 && !it.end_of_message)
        begin
            held_sym[n - 1] = sym[n - 1];
            group_len = 2'(n);
            return;
        end
        // short group at end of message: missing second symbol decodes as zero
        if (n < 2)
        begin
            sym[1] = b64d_pkg::SYM_VALID_ZERO;
        end
        if (n < 3)
        begin
            sym[2] = b64d_pkg::SYM_NONE;
        end
        if (n < 4)
        begin
            sym[3] = b64d_pkg::SYM_NONE;
        end
        group_len = 2'd0;
        held_sym[0] = b64d_pkg::SYM_NONE;
        held_sym[1] = b64d_pkg::SYM_NONE;
        held_sym[2] = b64d_pkg::SYM_NONE;
        if (!sym[0][6] || !sym[1][6])
        begin
            abort_message(b64d_pkg::STATUS_BAD_SYMBOL, it.end_of_message);
            return;
        end
        if (emitted >= capacity)
        begin
            abort_message(b64d_pkg::STATUS_FULL, it.end_of_message);
            return;
        end
        c_ok = sym[2][6];
        d_ok = sym[3][6];
        triple = {sym[0][5:0], sym[1][5:0],
                  c_ok ? sym[2][5:0] : 6'd0, d_ok ? sym[3][5:0] : 6'd0};
        out_bytes[0] = triple[23:16];
        cnt = 1;
        if (c_ok && int'(emitted) + cnt < int'(capacity))
        begin
            out_bytes[cnt] = triple[15:8];
            cnt++;
        end
        if (d_ok && int'(emitted) + cnt < int'(capacity))
        begin
            out_bytes[cnt] = triple[7:0];
            cnt++;
        end
        for (int i = 0; i < cnt; i++)
        begin
            emitted = emitted + 16'd1;
            r = '0;
            r.out_byte = out_bytes[i];
            r.byte_present = 1'b1;
            r.status = b64d_pkg::STATUS_OK;
            r.last = (i == cnt - 1);
            r.message_end = (i == cnt - 1) && it.end_of_message;
            r.written_count = emitted;
            decoded_queue.push_back(r);
        end
        if (it.end_of_message)
        begin
            clear_message();
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input b64d_pkg::result_t got);
        b64d_pkg::result_t want;
        if (decoded_queue.size() == 0)
        begin
            $error("result transaction with nothing decoded: out_byte %0d written_count %0d",
                   got.out_byte, got.written_count);
            fail_count++;
            return;
        end
        want = decoded_queue.pop_front();
        compare_field("out_byte", want.out_byte, got.out_byte);
        compare_field("byte_present", want.byte_present, got.byte_present);
        compare_field("status", want.status, got.status);
        compare_field("last", want.last, got.last);
        compare_field("message_end", want.message_end, got.message_end);
        compare_field("written_count", want.written_count, got.written_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity = b64d_pkg::CAP_RESET;
            clear_message();
            decoded_queue.delete();
            outstanding <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                capacity = cfg_write_data;
            end
            if (push && !full)
            begin
                decode_char(item);
            end
            if (pop && !empty)
            begin
                check_result(result);
            end
            outstanding <= decoded_queue.size();
            mismatches <= fail_count;
        end
    end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives base64 messages into the stream decoder: a directed set of padding,
// short group, bad symbol and output full cases, then random well-formed,
// broken and noise messages under changing capacities and handshake idling.
// ----------------------------------------------------------------------------
module testbench;

    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    b64d_pkg::item_t   item = '0;
    logic              empty;
    logic              pop = 1'b0;
    b64d_pkg::result_t result;
    logic              cfg_write_en = 1'b0;
    logic [15:0]       cfg_write_data = 16'd0;

    int mismatches;
    int outstanding;
    int send_idle = 0;
    int recv_idle = 0;
    int chars_sent = 0;

    base64_stream_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .item           (item),
        .empty          (empty),
        .pop            (pop),
        .result         (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    base64_decode_checker decode_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .item           (item),
        .empty          (empty),
        .pop            (pop),
        .result         (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        pop <= rst_n && ($urandom_range(0, 99) >= recv_idle);
    end

    function automatic logic [7:0] random_symbol_char();
        return ALPHABET[$urandom_range(0, 63)];
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eom);
        while ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= '{enc_char: c, end_of_message: eom};
        do @(posedge clk); while (full);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input logic eom);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], eom && (i == s.len() - 1));
        end
    endtask

    task automatic drain(input int tail);
        push <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        drain(8);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [15:0] pick_capacity();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'(int'($urandom_range(1, 3)));
            3: return 16'(int'($urandom_range(4, 24)));
            default: return 16'(int'($urandom_range(0, 65535)));
        endcase
    endfunction

    task automatic send_message();
        logic [7:0] chars[$];
        int kind;
        int groups;
        int len;
        kind = $urandom_range(0, 9);
        if (kind <= 7)
        begin
            groups = $urandom_range(0, 5);
            repeat (groups * 4) chars.push_back(random_symbol_char());
            case ($urandom_range(0, 3))
                1:
                begin
                    repeat (2) chars.push_back(random_symbol_char());
                    chars.push_back("=");
                    chars.push_back("=");
                end
                2:
                begin
                    repeat (3) chars.push_back(random_symbol_char());
                    chars.push_back("=");
                end
                3:
                begin
                    repeat ($urandom_range(1, 3)) chars.push_back(random_symbol_char());
                end
                default:
                begin
                end
            endcase
            if (chars.size() == 0)
            begin
                repeat (4) chars.push_back(random_symbol_char());
            end
            // broken message: one character replaced by any byte
            if (kind >= 6)
            begin
                chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
        else
        begin
            len = $urandom_range(1, 12);
            repeat (len)
            begin
                if (kind == 9 && $urandom_range(0, 4) != 0)
                begin
                    chars.push_back(random_symbol_char());
                end
                else
                begin
                    chars.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        for (int i = 0; i < chars.size(); i++)
        begin
            if (i != 0 && i % 4 == 0 && $urandom_range(0, 29) == 0)
            begin
                write_capacity(pick_capacity());
            end
            send_char(chars[i], i == chars.size() - 1);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("TWFu", 1'b1);
        send_text("////", 1'b1);
        send_text("AA==", 1'b1);
        send_text("Q", 1'b1);
        send_text("QUJ", 1'b1);
        // bad second symbol mid message, rest skipped up to end of message
        send_char("A", 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("AA", 1'b0);
        send_text("B9", 1'b1);
        send_char(8'h00, 1'b1);
        write_capacity(16'd0);
        send_text("Q", 1'b1);
        write_capacity(16'd4);
        send_text("TWFu", 1'b0);
        write_capacity(16'd3);
        send_text("TWFu", 1'b1);
        write_capacity(16'hFFFF);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 11;
                    recv_idle = 78;
                end
                1:
                begin
                    send_idle = 78;
                    recv_idle = 11;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            write_capacity(pick_capacity());
            while (chars_sent < 32 + 80 * (phase + 1))
            begin
                send_message();
                if ($urandom_range(0, 3) == 0)
                begin
                    write_capacity(pick_capacity());
                end
            end
        end

        drain(16);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> sim.f
design/b64d_pkg.sv
design/b64d_queue.sv
design/b64d_front.sv
design/b64d_back.sv
design/base64_stream_decoder.sv
tb/base64_decode_checker.sv
tb/testbench.sv
